// ===== hw/rtl/zsc_pkg.sv =====
// Shared constants, codes and controller/datapath types of the z-score standardizer.
package zsc_pkg;

   localparam int MAX_FEATURES = 16;
   localparam int FEAT_W       = $clog2(MAX_FEATURES);
   localparam int FCNT_W       = 5;
   localparam int FC_RESET     = 16;
   localparam int MAX_ROWS     = 65536;
   localparam int ROW_W        = 17;

   localparam int VALUE_W = 24;
   localparam int Z_W     = 17;
   localparam int SUM_W   = 40;
   localparam int SQ_W    = 63;
   localparam int TERM_W  = 47;
   localparam int PLIER_W = 40;
   localparam int PROD_W  = 2 * PLIER_W;
   localparam int DIVR_W  = 34;
   localparam int ROOT_W  = 24;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int SREM_W  = ROOT_W + 2;

   localparam int MUL_STEPS  = PLIER_W;
   localparam int DIV_LONG   = PROD_W;
   localparam int DIV_SHORT  = PLIER_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int MCNT_W     = $clog2(MUL_STEPS + 1);
   localparam int DCNT_W     = $clog2(DIV_LONG + 1);
   localparam int SCNT_W     = $clog2(SQRT_STEPS + 1);

   localparam int Z_LIMIT  = 32768;
   localparam int ONE_Q12  = 4096;
   localparam int Q_FRAC   = 12;

   typedef enum logic [1:0] {
      OP_ACC   = 2'd0,
      OP_CLOSE = 2'd1,
      OP_STD   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_MISMATCH = 2'd2,
      STAT_UNFIT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MUL_N_SQ,
      MUL_S_S,
      MUL_N_N
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_VAR,
      DIV_MEAN,
      DIV_Z
   } div_sel_type;

   typedef enum logic [4:0] {
      CS_IDLE,
      CS_ACC_SQ,
      CS_ACC_ADD,
      CS_MUL1,
      CS_MUL1_WAIT,
      CS_MUL2,
      CS_MUL2_WAIT,
      CS_MUL3,
      CS_MUL3_WAIT,
      CS_DIVV,
      CS_DIVV_WAIT,
      CS_SQRT,
      CS_SQRT_WAIT,
      CS_DIVM,
      CS_DIVM_WAIT,
      CS_WRITE,
      CS_ZDIV,
      CS_ZDIV_WAIT,
      CS_FINISH
   } state_type;

   typedef struct packed {
      logic              load_item;
      logic [FEAT_W-1:0] feature;
      logic [ROW_W-1:0]  rows;
      logic              acc_square;
      logic              acc_update;
      logic              clear_acc;
      logic              mul_start;
      mul_sel_type       mul_sel;
      logic              cap_prod;
      logic              cap_diff;
      logic              cap_nn;
      logic              div_start;
      div_sel_type       div_sel;
      logic              sqrt_start;
      logic              write_fit;
      logic              cap_z;
      logic              load_rsp;
      logic              rsp_zero;
      status_type        rsp_status;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
      logic sqrt_busy;
   } stat_type;

endpackage

// ===== hw/rtl/zsc_if.sv =====
// Channel interfaces of the z-score standardizer: request, response and register write.
interface zsc_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        opcode;
   logic [zsc_pkg::FEAT_W-1:0]        feature_index;
   logic signed [zsc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output opcode, output feature_index, output value,
                   input ready);
   modport sink   (input valid, input opcode, input feature_index, input value,
                   output ready);
endinterface

interface zsc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [zsc_pkg::Z_W-1:0] z_value;
   logic [1:0]                     status;

   modport source (output valid, output z_value, output status, input ready);
   modport sink   (input valid, input z_value, input status, output ready);
endinterface

interface zsc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [zsc_pkg::FCNT_W-1:0]  feature_count;

   modport source (output valid, output feature_count, input ready);
   modport sink   (input valid, input feature_count, output ready);
endinterface

// ===== hw/rtl/zsc_dp.sv =====
// Datapath: accumulators, fit tables, shift-add multiplier, divider and square root.
module zsc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [zsc_pkg::VALUE_W-1:0] req_value,
   input  zsc_pkg::cmd_type                  cmd,
   output zsc_pkg::stat_type                 stat,
   output logic signed [zsc_pkg::Z_W-1:0]    rsp_z_value,
   output logic [1:0]                        rsp_status
);
   import zsc_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic [TERM_W-1:0]         term_ff;
   logic signed [SUM_W-1:0]   value_sum_ff [MAX_FEATURES];
   logic [SQ_W-1:0]           square_sum_ff [MAX_FEATURES];
   logic signed [VALUE_W-1:0] mean_ff [MAX_FEATURES];
   logic [VALUE_W-1:0]        stdev_ff [MAX_FEATURES];

   logic [PROD_W-1:0]  mul_acc_ff, mul_cand_ff;
   logic [PLIER_W-1:0] mul_plier_ff;
   logic [MCNT_W-1:0]  mul_cnt_ff;
   logic [PROD_W-1:0]  prod_ff, diff_ff;
   logic [DIVR_W-1:0]  nn_ff;

   logic [PROD_W-1:0]  dvd_ff, quo_ff;
   logic [DIVR_W-1:0]  rem_ff, divisor_ff;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic               z_neg_ff;

   logic [RAD_W-1:0]   rad_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [SREM_W-1:0]  srem_ff;
   logic [SCNT_W-1:0]  sq_cnt_ff;

   logic signed [Z_W-1:0] z_res_ff;
   logic signed [Z_W-1:0] rsp_z_ff;
   logic [1:0]            rsp_status_ff;

   logic [VALUE_W-1:0]        mag_w;
   logic [2*VALUE_W-1:0]      term_w;
   logic signed [SUM_W-1:0]   sel_sum_w;
   logic [SUM_W-1:0]          smag_w;
   logic [SUM_W-1:0]          mnum_w;
   logic signed [VALUE_W-1:0] mean_sel_w;
   logic [VALUE_W-1:0]        sd_sel_w;
   logic signed [VALUE_W:0]   zdiff_w;
   logic [VALUE_W-1:0]        zmag_w;
   logic [PLIER_W-1:0]        znum_w;
   logic [DIVR_W:0]           r2_w, rsub_w;
   logic                      ge_w;
   logic [SREM_W+1:0]         sr2_w, trial_w, ssub_w;
   logic [Z_W-1:0]            zclamp_w;

   assign mag_w      = value_ff[VALUE_W-1] ? VALUE_W'(-value_ff) : VALUE_W'(value_ff);
   assign term_w     = (2*VALUE_W)'(mag_w) * (2*VALUE_W)'(mag_w);
   assign sel_sum_w  = value_sum_ff[cmd.feature];
   assign smag_w     = sel_sum_w[SUM_W-1] ? SUM_W'(-sel_sum_w) : SUM_W'(sel_sum_w);
   assign mnum_w     = smag_w + SUM_W'(cmd.rows >> 1);
   assign mean_sel_w = mean_ff[cmd.feature];
   assign sd_sel_w   = stdev_ff[cmd.feature];
   assign zdiff_w    = (VALUE_W+1)'(value_ff) - (VALUE_W+1)'(mean_sel_w);
   assign zmag_w     = zdiff_w[VALUE_W] ? VALUE_W'(-zdiff_w) : zdiff_w[VALUE_W-1:0];
   assign znum_w     = {4'b0, zmag_w, {Q_FRAC{1'b0}}} + PLIER_W'(sd_sel_w >> 1);

   assign r2_w   = {rem_ff, dvd_ff[PROD_W-1]};
   assign rsub_w = r2_w - {1'b0, divisor_ff};
   assign ge_w   = r2_w >= {1'b0, divisor_ff};

   assign sr2_w   = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial_w = {2'b00, root_ff, 2'b01};
   assign ssub_w  = sr2_w - trial_w;

   assign zclamp_w = (quo_ff > PROD_W'(Z_LIMIT)) ? Z_W'(Z_LIMIT) : {1'b0, quo_ff[Z_W-2:0]};

   // Item capture and square term.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         value_ff <= req_value;
      end
      if (cmd.acc_square) begin
         term_ff <= term_w[TERM_W-1:0];
      end
   end

   // Accumulators are cleared by reset and by every close.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_acc) begin
         for (int i = 0; i < MAX_FEATURES; i++) begin
            value_sum_ff[i]  <= '0;
            square_sum_ff[i] <= '0;
         end
      end else if (cmd.acc_update) begin
         value_sum_ff[cmd.feature]  <= value_sum_ff[cmd.feature] + SUM_W'(value_ff);
         square_sum_ff[cmd.feature] <= square_sum_ff[cmd.feature] + SQ_W'(term_ff);
      end
   end

   // Fit tables.
   always_ff @(posedge clock) begin
      if (cmd.write_fit) begin
         mean_ff[cmd.feature]  <= sel_sum_w[SUM_W-1] ? VALUE_W'(-quo_ff[VALUE_W-1:0])
                                                     : VALUE_W'(quo_ff[VALUE_W-1:0]);
         stdev_ff[cmd.feature] <= (root_ff == '0) ? VALUE_W'(ONE_Q12) : root_ff;
      end
   end

   // Step counters of the three iterative units.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_cnt_ff <= '0;
         div_cnt_ff <= '0;
         sq_cnt_ff  <= '0;
      end else begin
         if (cmd.mul_start) begin
            mul_cnt_ff <= MCNT_W'(MUL_STEPS);
         end else if (mul_cnt_ff != '0) begin
            mul_cnt_ff <= mul_cnt_ff - 1'b1;
         end
         if (cmd.div_start) begin
            div_cnt_ff <= (cmd.div_sel == DIV_VAR) ? DCNT_W'(DIV_LONG) : DCNT_W'(DIV_SHORT);
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (cmd.sqrt_start) begin
            sq_cnt_ff <= SCNT_W'(SQRT_STEPS);
         end else if (sq_cnt_ff != '0) begin
            sq_cnt_ff <= sq_cnt_ff - 1'b1;
         end
      end
   end

   // Shift-add multiplier, one multiplier bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mul_acc_ff <= '0;
         case (cmd.mul_sel)
            MUL_N_SQ: begin
               mul_cand_ff  <= PROD_W'(square_sum_ff[cmd.feature]);
               mul_plier_ff <= PLIER_W'(cmd.rows);
            end
            MUL_S_S: begin
               mul_cand_ff  <= PROD_W'(smag_w);
               mul_plier_ff <= PLIER_W'(smag_w);
            end
            default: begin
               mul_cand_ff  <= PROD_W'(cmd.rows);
               mul_plier_ff <= PLIER_W'(cmd.rows);
            end
         endcase
      end else if (mul_cnt_ff != '0) begin
         if (mul_plier_ff[0]) begin
            mul_acc_ff <= mul_acc_ff + mul_cand_ff;
         end
         mul_cand_ff  <= {mul_cand_ff[PROD_W-2:0], 1'b0};
         mul_plier_ff <= {1'b0, mul_plier_ff[PLIER_W-1:1]};
      end
      if (cmd.cap_prod) begin
         prod_ff <= mul_acc_ff;
      end
      if (cmd.cap_diff) begin
         diff_ff <= prod_ff - mul_acc_ff;
      end
      if (cmd.cap_nn) begin
         nn_ff <= mul_acc_ff[DIVR_W-1:0];
      end
   end

   // Restoring divider, one quotient bit per cycle. Short divisions sit in the upper half.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= '0;
         case (cmd.div_sel)
            DIV_VAR: begin
               dvd_ff     <= diff_ff;
               divisor_ff <= nn_ff;
            end
            DIV_MEAN: begin
               dvd_ff     <= {mnum_w, {PLIER_W{1'b0}}};
               divisor_ff <= DIVR_W'(cmd.rows);
            end
            default: begin
               dvd_ff     <= {znum_w, {PLIER_W{1'b0}}};
               divisor_ff <= DIVR_W'(sd_sel_w);
               z_neg_ff   <= zdiff_w[VALUE_W];
            end
         endcase
      end else if (div_cnt_ff != '0) begin
         rem_ff <= ge_w ? rsub_w[DIVR_W-1:0] : r2_w[DIVR_W-1:0];
         quo_ff <= {quo_ff[PROD_W-2:0], ge_w};
         dvd_ff <= {dvd_ff[PROD_W-2:0], 1'b0};
      end
   end

   // Digit-by-digit square root of the variance, two radicand bits per cycle.
   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rad_ff  <= quo_ff[RAD_W-1:0];
         root_ff <= '0;
         srem_ff <= '0;
      end else if (sq_cnt_ff != '0) begin
         if (sr2_w >= trial_w) begin
            srem_ff <= ssub_w[SREM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= sr2_w[SREM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
      end
   end

   // Result assembly.
   always_ff @(posedge clock) begin
      if (cmd.cap_z) begin
         z_res_ff <= z_neg_ff ? Z_W'(-zclamp_w) : Z_W'(zclamp_w);
      end
      if (cmd.load_rsp) begin
         rsp_z_ff      <= cmd.rsp_zero ? '0 : z_res_ff;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign stat.mul_busy  = (mul_cnt_ff != '0);
   assign stat.div_busy  = (div_cnt_ff != '0);
   assign stat.sqrt_busy = (sq_cnt_ff != '0);
   assign rsp_z_value    = rsp_z_ff;
   assign rsp_status     = rsp_status_ff;

   a_mul_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> mul_cnt_ff == '0)
      else $error("multiplier restarted while busy");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (div_cnt_ff == '0 && mul_cnt_ff == '0))
      else $error("divider started while an operand was still in work");
   a_sqrt_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> (sq_cnt_ff == '0 && div_cnt_ff == '0))
      else $error("square root started before the variance quotient was done");

endmodule

// ===== hw/rtl/zsc_ctrl.sv =====
// Controller: item decode, row and fit bookkeeping, and sequencing of the datapath.
module zsc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [zsc_pkg::FEAT_W-1:0]  req_feature_index,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [zsc_pkg::FCNT_W-1:0]  csr_feature_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output zsc_pkg::cmd_type            cmd,
   input  zsc_pkg::stat_type           stat
);
   import zsc_pkg::*;

   state_type          state_ff, state_in;
   logic [FEAT_W-1:0]  feature_ff, feature_in;
   logic [FEAT_W-1:0]  col_ff, col_in;
   status_type         code_ff, code_in;
   logic               zero_ff, zero_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   logic [FEAT_W-1:0]  expected_ff, expected_in;
   logic               fitted_ff, fitted_in;
   logic [FCNT_W-1:0]  fit_width_ff, fit_width_in;
   logic [FCNT_W-1:0]  feature_count_ff, feature_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FCNT_W-1:0]  fc;
   opcode_type         op_w;

   always_comb begin
      if (feature_count_ff == '0) begin
         fc = FCNT_W'(1);
      end else if (feature_count_ff > FCNT_W'(MAX_FEATURES)) begin
         fc = FCNT_W'(MAX_FEATURES);
      end else begin
         fc = feature_count_ff;
      end
   end

   assign op_w      = opcode_type'(req_opcode);
   assign req_ready = (state_ff == CS_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= CS_IDLE;
         row_count_ff     <= '0;
         expected_ff      <= '0;
         fitted_ff        <= 1'b0;
         fit_width_ff     <= '0;
         feature_count_ff <= FCNT_W'(FC_RESET);
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         row_count_ff     <= row_count_in;
         expected_ff      <= expected_in;
         fitted_ff        <= fitted_in;
         fit_width_ff     <= fit_width_in;
         feature_count_ff <= feature_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feature_ff <= feature_in;
      col_ff     <= col_in;
      code_ff    <= code_in;
      zero_ff    <= zero_in;
   end

   always_comb begin
      state_in         = state_ff;
      feature_in       = feature_ff;
      col_in           = col_ff;
      code_in          = code_ff;
      zero_in          = zero_ff;
      row_count_in     = row_count_ff;
      expected_in      = expected_ff;
      fitted_in        = fitted_ff;
      fit_width_in     = fit_width_ff;
      feature_count_in = csr_valid ? csr_feature_count : feature_count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;

      cmd            = '0;
      cmd.feature    = feature_ff;
      cmd.rows       = row_count_ff;
      cmd.mul_sel    = MUL_N_SQ;
      cmd.div_sel    = DIV_VAR;
      cmd.rsp_status = code_ff;
      cmd.rsp_zero   = zero_ff;

      if (state_ff inside {[CS_MUL1:CS_WRITE]}) begin
         cmd.feature = col_ff;
      end

      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               feature_in    = req_feature_index;
               zero_in       = 1'b1;
               code_in       = STAT_OK;
               state_in      = CS_FINISH;
               case (op_w)
                  OP_ACC: begin
                     if (req_feature_index != expected_ff ||
                         FCNT_W'(req_feature_index) >= fc ||
                         (req_feature_index == '0 && row_count_ff >= ROW_W'(MAX_ROWS))) begin
                        code_in = STAT_MISMATCH;
                     end else begin
                        state_in = CS_ACC_SQ;
                     end
                  end
                  OP_CLOSE: begin
                     if (expected_ff != '0 || row_count_ff == '0) begin
                        code_in       = (expected_ff != '0) ? STAT_MISMATCH : STAT_EMPTY;
                        cmd.clear_acc = 1'b1;
                        row_count_in  = '0;
                        expected_in   = '0;
                     end else begin
                        col_in   = '0;
                        state_in = CS_MUL1;
                     end
                  end
                  OP_STD: begin
                     if (!fitted_ff) begin
                        code_in = STAT_UNFIT;
                     end else if (FCNT_W'(req_feature_index) >= fit_width_ff) begin
                        code_in = STAT_MISMATCH;
                     end else begin
                        state_in = CS_ZDIV;
                     end
                  end
                  default: begin
                     code_in = STAT_OK;
                  end
               endcase
            end
         end
         CS_ACC_SQ: begin
            cmd.acc_square = 1'b1;
            state_in       = CS_ACC_ADD;
         end
         CS_ACC_ADD: begin
            cmd.acc_update = 1'b1;
            if (FCNT_W'(feature_ff) + 1'b1 == fc) begin
               row_count_in = row_count_ff + 1'b1;
               expected_in  = '0;
            end else begin
               expected_in = feature_ff + 1'b1;
            end
            state_in = CS_FINISH;
         end
         CS_MUL1: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_N_SQ;
            state_in      = CS_MUL1_WAIT;
         end
         CS_MUL1_WAIT: begin
            if (!stat.mul_busy) begin
               cmd.cap_prod = 1'b1;
               state_in     = CS_MUL2;
            end
         end
         CS_MUL2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_S_S;
            state_in      = CS_MUL2_WAIT;
         end
         CS_MUL2_WAIT: begin
            if (!stat.mul_busy) begin
               cmd.cap_diff = 1'b1;
               state_in     = CS_MUL3;
            end
         end
         CS_MUL3: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MUL_N_N;
            state_in      = CS_MUL3_WAIT;
         end
         CS_MUL3_WAIT: begin
            if (!stat.mul_busy) begin
               cmd.cap_nn = 1'b1;
               state_in   = CS_DIVV;
            end
         end
         CS_DIVV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
            state_in      = CS_DIVV_WAIT;
         end
         CS_DIVV_WAIT: begin
            if (!stat.div_busy) begin
               state_in = CS_SQRT;
            end
         end
         CS_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = CS_SQRT_WAIT;
         end
         CS_SQRT_WAIT: begin
            if (!stat.sqrt_busy) begin
               state_in = CS_DIVM;
            end
         end
         CS_DIVM: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
            state_in      = CS_DIVM_WAIT;
         end
         CS_DIVM_WAIT: begin
            if (!stat.div_busy) begin
               state_in = CS_WRITE;
            end
         end
         CS_WRITE: begin
            cmd.write_fit = 1'b1;
            if (FCNT_W'(col_ff) + 1'b1 == fc) begin
               fitted_in     = 1'b1;
               fit_width_in  = fc;
               cmd.clear_acc = 1'b1;
               row_count_in  = '0;
               expected_in   = '0;
               code_in       = STAT_OK;
               zero_in       = 1'b1;
               state_in      = CS_FINISH;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = CS_MUL1;
            end
         end
         CS_ZDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_Z;
            state_in      = CS_ZDIV_WAIT;
         end
         CS_ZDIV_WAIT: begin
            if (!stat.div_busy) begin
               cmd.cap_z = 1'b1;
               code_in   = STAT_OK;
               zero_in   = 1'b0;
               state_in  = CS_FINISH;
            end
         end
         CS_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   a_fit_width: assert property (@(posedge clock) disable iff (reset)
      fitted_ff |-> fit_width_ff != '0)
      else $error("fit in force with zero width");
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= ROW_W'(MAX_ROWS))
      else $error("row count beyond training set limit");
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten before it was taken");

endmodule

// ===== hw/rtl/zscore_fit_and_transform_core.sv =====
// Top level of the z-score standardizer: channel ports, controller and datapath.
// Every item gives one result item; a good close runs the bit-serial multiplier, divider and
// square root for each feature before its result item.
// Throughput: one item at a time; the next is accepted once the result register loads.
// Synchronous active-high reset clears accumulators, row count and fit flag and sets
// feature_count to 16; means and deviations stay unset until the first good close.
module zscore_fit_and_transform_core (
   input logic         clock,
   input logic         reset,
   zsc_req_if.sink     req_ch,
   zsc_rsp_if.source   rsp_ch,
   zsc_csr_if.sink     csr_ch
);
   import zsc_pkg::*;

   // Commands flow from the controller to the datapath, busy flags come back.
   cmd_type  cmd;
   stat_type stat;

   // The controller owns the handshakes, the row and fit bookkeeping and the
   // feature_count register; it drives the datapath one step at a time.
   zsc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_opcode        (req_ch.opcode),
      .req_feature_index (req_ch.feature_index),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_feature_count (csr_ch.feature_count),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .cmd               (cmd),
      .stat              (stat)
   );

   // The datapath holds the per-feature sums and fit tables and the iterative
   // arithmetic units, and it registers the outgoing result item.
   zsc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_ch.value),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_z_value (rsp_ch.z_value),
      .rsp_status  (rsp_ch.status)
   );

endmodule
